// ===== sv/led_pixel_store_with_brightness_top_assert.svh =====
// assertion macros for the led pixel store checker
// expects clk and rst_n in the scope where a macro is used
`ifndef LED_PIXEL_STORE_WITH_BRIGHTNESS_TOP_ASSERT_SVH
`define LED_PIXEL_STORE_WITH_BRIGHTNESS_TOP_ASSERT_SVH

// consequent must hold in the same cycle
`define LPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("led pixel store check failed");

// consequent must hold in the next cycle
`define LPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("led pixel store check failed");

`endif

// ===== sv/lps_pkg.sv =====
// shared types, codes and helpers for the led pixel store
// no dependencies
package lps_pkg;

    // default strip length
    localparam int STRIP_LEN_DEF = 64;

    // register reset values
    localparam logic [6:0] LED_COUNT_RST  = 7'd64;
    localparam logic       WHITE_RST      = 1'b0;
    localparam logic [7:0] BRIGHTNESS_RST = 8'd255;
    localparam logic [7:0] BRIGHT_FULL    = 8'hFF;

    // register indexes
    localparam logic [1:0] REG_LED_COUNT  = 2'd0;
    localparam logic [1:0] REG_WHITE      = 2'd1;
    localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

    // action codes
    localparam logic [2:0] ACT_SET_RGB   = 3'd0;
    localparam logic [2:0] ACT_SET_RGBW  = 3'd1;
    localparam logic [2:0] ACT_FILL_RGB  = 3'd2;
    localparam logic [2:0] ACT_FILL_RGBW = 3'd3;
    localparam logic [2:0] ACT_REEMIT    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NOSUP = 2'd2;

    typedef struct packed {
        logic [2:0] action;
        logic [5:0] pixel_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] white_in;
    } in_word_t;

    typedef struct packed {
        logic       write_valid;
        logic [5:0] out_index;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] white_out;
        logic [1:0] status;
        logic       last;
    } out_word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_READ,
        S_EMIT
    } state_t;

    // brightness scaling of one color byte
    function automatic logic [7:0] scale_byte(input logic [7:0] v, input logic [7:0] br);
        logic [16:0] prod;
        prod = v * ({1'b0, br} + 9'd1);
        if (br == BRIGHT_FULL)
            return v;
        return prod[15:8];
    endfunction

endpackage

// ===== sv/led_pixel_store_with_brightness_top.sv =====
// Set actions: result word in the output register the cycle after acceptance, one set per cycle
// unless the output stalls. Fill: one result per pixel in use, one per cycle unless the output
// stalls (written straight from the input word). Re-emit: per pixel a read state, then an emit
// state, as the pixel store has a registered read. The input stalls while a fill or re-emit runs
// or while a finished word waits to be taken. Reset (rst_n, async, low): registers to defaults,
// per-pixel valid bits cleared so the store reads as zero at once; no clearing pass.
module led_pixel_store_with_brightness_top #(
    parameter int STRIP_LEN = lps_pkg::STRIP_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  lps_pkg::in_word_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output lps_pkg::out_word_t out_data
);

    localparam int         IDX_W   = (STRIP_LEN > 1) ? $clog2(STRIP_LEN) : 1;
    localparam logic [6:0] MAX_CNT = 7'(STRIP_LEN);

    // configuration registers
    logic [6:0] led_count_reg;
    logic       white_reg;
    logic [7:0] bright_reg;

    // control
    lps_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      fill_word_reg, fill_word_next;

    // pixel store and its valid bits
    logic [31:0]          mem [STRIP_LEN];
    logic [STRIP_LEN-1:0] vld_reg;
    logic [31:0]          rd_data_reg;
    logic                 rd_vld_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_addr;
    logic [31:0]          mem_wdata;
    logic                 rd_en;

    // output register
    logic               out_valid_reg;
    lps_pkg::out_word_t out_word_reg;
    logic               load;
    lps_pkg::out_word_t load_word;

    logic [6:0]  n_act;
    logic        last_pix;
    logic        out_free;
    logic        in_take;
    logic        is_rgb;
    logic [31:0] in_pix;

    // scaled pixel word
    function automatic lps_pkg::out_word_t make_pixel(input logic [5:0] idx,
                                                      input logic [31:0] p,
                                                      input logic white,
                                                      input logic [7:0] br,
                                                      input logic lst);
        lps_pkg::out_word_t o;
        o.write_valid = 1'b1;
        o.out_index   = idx;
        o.red_out     = lps_pkg::scale_byte(p[7:0], br);
        o.green_out   = lps_pkg::scale_byte(p[15:8], br);
        o.blue_out    = lps_pkg::scale_byte(p[23:16], br);
        o.white_out   = white ? lps_pkg::scale_byte(p[31:24], br) : 8'd0;
        o.status      = lps_pkg::ST_OK;
        o.last        = lst;
        return o;
    endfunction

    // error word with all payload cleared
    function automatic lps_pkg::out_word_t make_status(input logic [1:0] st);
        lps_pkg::out_word_t o;
        o        = '0;
        o.status = st;
        o.last   = 1'b1;
        return o;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= lps_pkg::LED_COUNT_RST;
            white_reg     <= lps_pkg::WHITE_RST;
            bright_reg    <= lps_pkg::BRIGHTNESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lps_pkg::REG_LED_COUNT:  led_count_reg <= cfg_data[6:0];
                lps_pkg::REG_WHITE:      white_reg     <= cfg_data[0];
                lps_pkg::REG_BRIGHTNESS: bright_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // pixels in use, saturated at the store depth
    assign n_act    = (led_count_reg > MAX_CNT) ? MAX_CNT : led_count_reg;
    assign last_pix = ((7'(cnt_reg) + 7'd1) == n_act);

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != lps_pkg::S_IDLE) || !out_free;
    assign in_take  = in_valid && !in_stall;

    // raw word from the input, white cleared for rgb actions
    assign is_rgb = (in_data.action == lps_pkg::ACT_SET_RGB) ||
                    (in_data.action == lps_pkg::ACT_FILL_RGB);
    assign in_pix = {is_rgb ? 8'd0 : in_data.white_in, in_data.blue_in,
                     in_data.green_in, in_data.red_in};

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_word_next = fill_word_reg;
        mem_we         = 1'b0;
        mem_addr       = cnt_reg;
        mem_wdata      = fill_word_reg;
        rd_en          = 1'b0;
        load           = 1'b0;
        load_word      = '0;
        unique case (state_reg)
            lps_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    unique case (in_data.action) inside
                        lps_pkg::ACT_SET_RGB, lps_pkg::ACT_SET_RGBW:
                        begin
                            load = 1'b1;
                            if (!is_rgb && !white_reg)
                                load_word = make_status(lps_pkg::ST_NOSUP);
                            else if ({1'b0, in_data.pixel_index} >= n_act)
                                load_word = make_status(lps_pkg::ST_RANGE);
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_addr  = in_data.pixel_index[IDX_W-1:0];
                                mem_wdata = in_pix;
                                load_word = make_pixel(in_data.pixel_index, in_pix,
                                                       white_reg, bright_reg, 1'b1);
                            end
                        end
                        lps_pkg::ACT_FILL_RGB, lps_pkg::ACT_FILL_RGBW:
                        begin
                            if (!is_rgb && !white_reg)
                            begin
                                load      = 1'b1;
                                load_word = make_status(lps_pkg::ST_NOSUP);
                            end
                            else if (n_act != 7'd0)
                            begin
                                fill_word_next = in_pix;
                                cnt_next       = '0;
                                state_next     = lps_pkg::S_FILL;
                            end
                        end
                        lps_pkg::ACT_REEMIT:
                        begin
                            if (n_act != 7'd0)
                            begin
                                cnt_next   = '0;
                                state_next = lps_pkg::S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            lps_pkg::S_FILL:
            begin
                if (out_free)
                begin
                    mem_we    = 1'b1;
                    load      = 1'b1;
                    load_word = make_pixel(6'(cnt_reg), fill_word_reg,
                                           white_reg, bright_reg, last_pix);
                    if (last_pix)
                        state_next = lps_pkg::S_IDLE;
                    else
                        cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            lps_pkg::S_READ:
            begin
                rd_en      = 1'b1;
                state_next = lps_pkg::S_EMIT;
            end
            lps_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    load_word = make_pixel(6'(cnt_reg), rd_vld_reg ? rd_data_reg : 32'd0,
                                           white_reg, bright_reg, last_pix);
                    if (last_pix)
                        state_next = lps_pkg::S_IDLE;
                    else
                    begin
                        cnt_next   = cnt_reg + IDX_W'(1);
                        state_next = lps_pkg::S_READ;
                    end
                end
            end
            default: state_next = lps_pkg::S_IDLE;
        endcase
    end

    // state and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lps_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // fill word holds no control state
    always_ff @(posedge clk)
    begin
        fill_word_reg <= fill_word_next;
    end

    // pixel store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[cnt_reg];
    end

    // per-pixel valid bits, unwritten pixels read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                vld_reg[mem_addr] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= vld_reg[cnt_reg];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_word_reg <= load_word;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

// ===== sv/lps_checker.sv =====
// port-level checks for the led pixel store, bound to the top level
// depends on lps_pkg and the assertion macro header
`include "led_pixel_store_with_brightness_top_assert.svh"

module lps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input lps_pkg::in_word_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input lps_pkg::out_word_t out_data
);

    logic set_take;
    logic err_st;

    // set action taken this cycle
    assign set_take = in_valid && !in_stall &&
                      (in_data.action == lps_pkg::ACT_SET_RGB ||
                       in_data.action == lps_pkg::ACT_SET_RGBW);
    assign err_st   = (out_data.status != lps_pkg::ST_OK);

    // a stalled output word holds
    `LPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // an error word is always the final word and carries a nonzero status
    `LPS_ASSERT_NOW(a_err_last, out_valid && !out_data.write_valid, out_data.last && err_st)

    // a pixel word always carries ok status
    `LPS_ASSERT_NOW(a_pix_ok, out_valid && out_data.write_valid, !err_st)

    // a set action gives its single word in the next cycle
    `LPS_ASSERT_NEXT(a_set_resp, set_take, out_valid && out_data.last)

    // while a strip run is in progress no new word is taken
    `LPS_ASSERT_NOW(a_run_busy, out_valid && !out_data.last, in_stall)

endmodule

bind led_pixel_store_with_brightness_top lps_checker u_lps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the led pixel store with global brightness
// depends on lps_pkg and led_pixel_store_with_brightness_top
module tb_top;

    localparam int          LIMIT_CYCLES  = 2000000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASES        = 10;
    localparam int          PHASE_WORDS   = 29;
    localparam logic [1:0]  REG_SPARE     = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [7:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    lps_pkg::in_word_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    lps_pkg::out_word_t out_data;

    // local copy of the strip and its registers
    logic [31:0]        strip_mem [64];
    logic [6:0]         count_reg;
    logic               white_mode;
    logic [7:0]         bright_reg;
    lps_pkg::out_word_t scaled_writes_q[$];

    // run bookkeeping
    int errors = 0;
    int cycles = 0;
    int accepted_words = 0;
    int ignored_words = 0;
    int fill_words = 0;
    int reemit_words = 0;
    int results_checked = 0;
    int reg_writes = 0;

    // sender and receiver pacing
    bit gaps_on = 1'b1;
    int burst_left = 0;
    int stall_mode = 1;
    int hold_req = 0;
    int hold_left = 0;
    int run_left = 0;
    bit run_stall = 1'b0;

    led_pixel_store_with_brightness_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     scaled_writes_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // brightness scaling of one color byte
    function automatic logic [7:0] dim(input logic [7:0] v);
        int unsigned prod;
        if (bright_reg == lps_pkg::BRIGHT_FULL)
            return v;
        prod = int'(v) * (int'(bright_reg) + 1);
        return 8'(prod >> 8);
    endfunction

    function automatic lps_pkg::out_word_t status_word(input logic [1:0] st);
        lps_pkg::out_word_t o;
        o = '0;
        o.status = st;
        o.last = 1'b1;
        return o;
    endfunction

    function automatic lps_pkg::out_word_t pixel_word(input int unsigned idx,
                                                      input bit is_last);
        lps_pkg::out_word_t o;
        logic [31:0]        px;
        px = strip_mem[idx];
        o.write_valid = 1'b1;
        o.out_index = idx[5:0];
        o.red_out = dim(px[7:0]);
        o.green_out = dim(px[15:8]);
        o.blue_out = dim(px[23:16]);
        o.white_out = white_mode ? dim(px[31:24]) : 8'h00;
        o.status = lps_pkg::ST_OK;
        o.last = is_last;
        return o;
    endfunction

    function automatic int unsigned pixels_in_use();
        return (count_reg > lps_pkg::STRIP_LEN_DEF) ? lps_pkg::STRIP_LEN_DEF : int'(count_reg);
    endfunction

    // update the local strip for one accepted word and queue the writes it causes
    task automatic apply_action(input lps_pkg::in_word_t w);
        int unsigned n;
        logic [7:0]  white_b;
        logic [31:0] px;
        accepted_words++;
        if (w.action > lps_pkg::ACT_REEMIT)
        begin
            ignored_words++;
            return;
        end
        n = pixels_in_use();
        // white actions are refused in rgb mode before any index check
        if ((w.action == lps_pkg::ACT_SET_RGBW || w.action == lps_pkg::ACT_FILL_RGBW) &&
            !white_mode)
        begin
            scaled_writes_q.push_back(status_word(lps_pkg::ST_NOSUP));
            return;
        end
        white_b = (w.action == lps_pkg::ACT_SET_RGB || w.action == lps_pkg::ACT_FILL_RGB) ?
                  8'h00 : w.white_in;
        px = {white_b, w.blue_in, w.green_in, w.red_in};
        if (w.action == lps_pkg::ACT_SET_RGB || w.action == lps_pkg::ACT_SET_RGBW)
        begin
            if (w.pixel_index >= n)
                scaled_writes_q.push_back(status_word(lps_pkg::ST_RANGE));
            else
            begin
                strip_mem[w.pixel_index] = px;
                scaled_writes_q.push_back(pixel_word(w.pixel_index, 1'b1));
            end
            return;
        end
        if (w.action == lps_pkg::ACT_REEMIT)
            reemit_words++;
        else
            fill_words++;
        // whole strip in use, one write per pixel
        for (int unsigned i = 0; i < n; i++)
        begin
            if (w.action != lps_pkg::ACT_REEMIT)
                strip_mem[i] = px;
            scaled_writes_q.push_back(pixel_word(i, i + 1 == n));
        end
    endtask

    function automatic lps_pkg::in_word_t make_word(input logic [2:0] act,
                                                    input logic [5:0] idx,
                                                    input logic [7:0] r, input logic [7:0] g,
                                                    input logic [7:0] b, input logic [7:0] w);
        lps_pkg::in_word_t x;
        x.action = act;
        x.pixel_index = idx;
        x.red_in = r;
        x.green_in = g;
        x.blue_in = b;
        x.white_in = w;
        return x;
    endfunction

    // color byte with extra weight on the extremes
    function automatic logic [7:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic lps_pkg::in_word_t rand_word();
        int unsigned pick;
        int unsigned n;
        logic [2:0]  act;
        logic [5:0]  idx;
        pick = $urandom_range(0, 99);
        n = pixels_in_use();
        if (pick < 30)
            act = lps_pkg::ACT_SET_RGB;
        else if (pick < 55)
            act = lps_pkg::ACT_SET_RGBW;
        else if (pick < 67)
            act = lps_pkg::ACT_FILL_RGB;
        else if (pick < 77)
            act = lps_pkg::ACT_FILL_RGBW;
        else if (pick < 91)
            act = lps_pkg::ACT_REEMIT;
        else
            act = 3'($urandom_range(5, 7));
        // mostly pixels in use, some anywhere
        if (n > 0 && $urandom_range(0, 3) != 0)
            idx = 6'($urandom_range(0, n - 1));
        else
            idx = 6'($urandom_range(0, 63));
        return make_word(act, idx, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endfunction

    // offer one word, in bursts with random gaps, and record it once taken
    task automatic send_word(input lps_pkg::in_word_t w);
        int gap_len;
        if (gaps_on && burst_left == 0)
        begin
            gap_len = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap_len) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        else
        begin
            @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_stall);
        apply_action(w);
    endtask

    // stop offering and let every expected write arrive
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (scaled_writes_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        reg_writes++;
        case (idx)
            lps_pkg::REG_LED_COUNT:  count_reg = val[6:0];
            lps_pkg::REG_WHITE:      white_mode = val[0];
            lps_pkg::REG_BRIGHTNESS: bright_reg = val;
            default:                 ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 2) == 0);
        else if (stall_mode == 2)
        begin
            if (run_left == 0)
            begin
                run_stall = !run_stall;
                run_left = run_stall ? $urandom_range(1, 8) : $urandom_range(1, 10);
            end
            run_left--;
            out_stall <= run_stall;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic void cmp_field(input string name, input int unsigned want,
                                      input logic [7:0] got);
        if (got !== want[7:0])
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // compare each taken result word with the oldest expected write
    always @(posedge clk)
    begin : check_result
        lps_pkg::out_word_t got;
        lps_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = out_data;
            if (scaled_writes_q.size() == 0)
            begin
                $error("unexpected result word: index %0d status %0d", got.out_index,
                       got.status);
                errors++;
            end
            else
            begin
                want = scaled_writes_q.pop_front();
                results_checked++;
                cmp_field("write_valid", want.write_valid, 8'(got.write_valid));
                cmp_field("out_index", want.out_index, 8'(got.out_index));
                cmp_field("red_out", want.red_out, got.red_out);
                cmp_field("green_out", want.green_out, got.green_out);
                cmp_field("blue_out", want.blue_out, got.blue_out);
                cmp_field("white_out", want.white_out, got.white_out);
                cmp_field("status", want.status, 8'(got.status));
                cmp_field("last", want.last, 8'(got.last));
            end
        end
    end

    // cleared store, default registers, white actions refused in rgb mode
    task automatic test_reset_defaults();
        send_word(make_word(lps_pkg::ACT_REEMIT, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(make_word(lps_pkg::ACT_SET_RGBW, 6'd5, 8'h11, 8'h22, 8'h33, 8'h44));
        send_word(make_word(lps_pkg::ACT_FILL_RGBW, 6'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(lps_pkg::ACT_SET_RGB, 6'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(lps_pkg::ACT_SET_RGB, 6'd63, 8'h00, 8'h80, 8'h01, 8'hFF));
    endtask

    // scaling at zero, middle and one below full brightness
    task automatic test_brightness_scaling();
        wait_idle();
        write_reg(lps_pkg::REG_BRIGHTNESS, 8'd0);
        send_word(make_word(lps_pkg::ACT_SET_RGB, 6'd1, 8'hFF, 8'h7F, 8'h01, 8'h00));
        wait_idle();
        write_reg(lps_pkg::REG_BRIGHTNESS, 8'd127);
        send_word(make_word(lps_pkg::ACT_SET_RGB, 6'd2, 8'hFF, 8'h80, 8'hC3, 8'h00));
        wait_idle();
        write_reg(lps_pkg::REG_BRIGHTNESS, 8'd254);
        send_word(make_word(lps_pkg::ACT_SET_RGB, 6'd3, 8'hFF, 8'hFE, 8'h01, 8'h00));
        send_word(make_word(lps_pkg::ACT_REEMIT, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // rgbw mode, rgb writes clearing white, mode changes on stored pixels
    task automatic test_white_mode();
        wait_idle();
        write_reg(lps_pkg::REG_WHITE, 8'd1);
        write_reg(lps_pkg::REG_BRIGHTNESS, 8'd255);
        send_word(make_word(lps_pkg::ACT_SET_RGBW, 6'd4, 8'h10, 8'h20, 8'h30, 8'hFF));
        send_word(make_word(lps_pkg::ACT_SET_RGB, 6'd4, 8'h40, 8'h50, 8'h60, 8'hFF));
        send_word(make_word(lps_pkg::ACT_FILL_RGBW, 6'd0, 8'hA5, 8'h5A, 8'hFF, 8'h81));
        wait_idle();
        write_reg(lps_pkg::REG_LED_COUNT, 8'd8);
        send_word(make_word(lps_pkg::ACT_SET_RGBW, 6'd7, 8'h01, 8'h02, 8'h03, 8'hFE));
        wait_idle();
        write_reg(lps_pkg::REG_WHITE, 8'd0);
        send_word(make_word(lps_pkg::ACT_REEMIT, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_idle();
        write_reg(lps_pkg::REG_WHITE, 8'd1);
        send_word(make_word(lps_pkg::ACT_REEMIT, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // single pixel, empty strip, saturated count, spare register index
    task automatic test_count_limits();
        wait_idle();
        write_reg(lps_pkg::REG_LED_COUNT, 8'd1);
        send_word(make_word(lps_pkg::ACT_SET_RGBW, 6'd0, 8'h12, 8'h34, 8'h56, 8'h78));
        send_word(make_word(lps_pkg::ACT_SET_RGB, 6'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(lps_pkg::ACT_SET_RGBW, 6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(lps_pkg::ACT_FILL_RGB, 6'd0, 8'h9C, 8'h00, 8'hFF, 8'hFF));
        wait_idle();
        write_reg(lps_pkg::REG_LED_COUNT, 8'd0);
        send_word(make_word(lps_pkg::ACT_SET_RGB, 6'd0, 8'h01, 8'h01, 8'h01, 8'h01));
        send_word(make_word(lps_pkg::ACT_FILL_RGB, 6'd0, 8'h02, 8'h02, 8'h02, 8'h02));
        send_word(make_word(lps_pkg::ACT_REEMIT, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_idle();
        // rgbw refused ahead of the range check
        write_reg(lps_pkg::REG_WHITE, 8'd0);
        send_word(make_word(lps_pkg::ACT_SET_RGBW, 6'd40, 8'h03, 8'h03, 8'h03, 8'h03));
        wait_idle();
        write_reg(lps_pkg::REG_LED_COUNT, 8'hFF);
        write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
        send_word(make_word(lps_pkg::ACT_REEMIT, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_idle();
        write_reg(lps_pkg::REG_LED_COUNT, 8'hC1);
        send_word(make_word(lps_pkg::ACT_SET_RGB, 6'd63, 8'h7E, 8'h81, 8'h00, 8'h00));
    endtask

    // undefined actions leave the strip untouched
    task automatic test_unknown_actions();
        wait_idle();
        write_reg(lps_pkg::REG_LED_COUNT, 8'd4);
        for (int a = 5; a <= 7; a++)
            send_word(make_word(3'(a), 6'($urandom_range(0, 63)), rand_byte(), rand_byte(),
                                rand_byte(), rand_byte()));
        send_word(make_word(lps_pkg::ACT_REEMIT, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // long receiver hold-off while words keep coming
    task automatic test_backpressure();
        wait_idle();
        write_reg(lps_pkg::REG_LED_COUNT, 8'd6);
        write_reg(lps_pkg::REG_WHITE, 8'd1);
        gaps_on = 1'b0;
        stall_mode = 0;
        @(posedge clk);
        hold_req = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 8 == 5)
                send_word(make_word(lps_pkg::ACT_FILL_RGBW, 6'd0, rand_byte(), rand_byte(),
                                    rand_byte(), rand_byte()));
            else
                send_word(make_word(i[0] ? lps_pkg::ACT_SET_RGBW : lps_pkg::ACT_SET_RGB,
                                    6'($urandom_range(0, 7)), rand_byte(), rand_byte(),
                                    rand_byte(), rand_byte()));
        end
        gaps_on = 1'b1;
        stall_mode = 2;
    endtask

    // random phases, each with its own register settings and pacing
    task automatic test_random_phases();
        int unsigned       pick;
        int                good;
        logic [6:0]        cnt;
        logic [7:0]        br;
        lps_pkg::in_word_t w;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 62)
                cnt = 7'($urandom_range(1, 8));
            else if (pick < 76)
                cnt = 7'($urandom_range(9, 24));
            else if (pick < 82)
                cnt = 7'($urandom_range(25, 63));
            else if (pick < 88)
                cnt = 7'd64;
            else if (pick < 94)
                cnt = 7'($urandom_range(65, 127));
            else
                cnt = 7'd0;
            pick = $urandom_range(0, 7);
            if (pick < 4)
                br = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 : (pick == 2) ? 8'd254 : 8'd255;
            else
                br = 8'($urandom_range(0, 255));
            write_reg(lps_pkg::REG_LED_COUNT, {1'($urandom_range(0, 1)), cnt});
            write_reg(lps_pkg::REG_WHITE, {7'($urandom_range(0, 127)),
                                           1'($urandom_range(0, 1))});
            write_reg(lps_pkg::REG_BRIGHTNESS, br);
            stall_mode = $urandom_range(0, 2);
            gaps_on = ($urandom_range(0, 3) != 0);
            good = 0;
            while (good < PHASE_WORDS)
            begin
                w = rand_word();
                send_word(w);
                if (w.action <= lps_pkg::ACT_REEMIT)
                    good++;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < 64; i++)
            strip_mem[i] = '0;
        count_reg = lps_pkg::LED_COUNT_RST;
        white_mode = lps_pkg::WHITE_RST;
        bright_reg = lps_pkg::BRIGHTNESS_RST;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_brightness_scaling();
        test_white_mode();
        test_count_limits();
        test_unknown_actions();
        test_backpressure();
        test_random_phases();
        wait_idle();

        $display("covered %0d words in (%0d fills, %0d re-emits, %0d ignored), %0d writes",
                 accepted_words, fill_words, reemit_words, ignored_words, reg_writes);
        $display("checked %0d result words, %0d mismatches", results_checked, errors);
        if (errors == 0 && scaled_writes_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
